/* design/rlm_pkg.sv */
package rlm_pkg;

  // Fixed field widths of the sample and result words
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;

endpackage

/* design/rlm_if.sv */
// Sample stream: one signed sample per word, last marks the end of a run
interface rlm_in_if;
  logic                           valid;
  logic                           ready;
  logic [rlm_pkg::SAMPLE_W-1:0]   sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Result stream: one level word per run
interface rlm_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlm_pkg::LEVEL_W-1:0]    level;
  logic                           overflow;

  modport source (output valid, output level, output overflow, input ready);
  modport sink   (input valid, input level, input overflow, output ready);
endinterface

/* design/rms_level_meter.sv */
// rms_level_meter: root mean square level of a run of signed samples.
//
// Input channel in_ch carries one sample word (sample, last). The low
// SAMPLE_BITS bits of sample are taken as a signed value. Each accepted word
// adds the exact square of its sample to an accumulator and bumps a count;
// after MAX_LEN samples further ones are dropped and overflow is flagged.
// The word marked last closes the run: the block then produces one result
// word on out_ch, level = floor(sqrt(floor(sum / count))), plus overflow.
//
// Sequence: a word without last is accepted, then squared and accumulated.
// A last word is handled the same way and then passes a load step, a restoring
// divide with one quotient bit a cycle, then a digit-by-digit square root with
// one root bit a cycle, both on one shared subtractor, before its result is
// registered. in_ch.ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver does not stop
// the next run from being accumulated, only the hand-off of the next result.
// Reset (synchronous, rst_n low) clears the sum, count, overflow flag,
// sequencer and output valid.
module rms_level_meter #(
  parameter int MAX_LEN     = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  rlm_in_if.sink          in_ch,
  rlm_out_if.source       out_ch
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int Q_W    = 2 * SB - 1;
  localparam int SUM_W  = Q_W + CNT_W;
  localparam int U_W    = (CNT_W + 1 > SB + 2) ? CNT_W + 1 : SB + 2;
  localparam int R_W    = U_W - 1;
  localparam int STEP_W = $clog2(Q_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                       state_r;
  logic [SB-1:0]                mag_r;
  logic                         last_r;
  logic [SUM_W-1:0]             sum_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         ovf_r;
  logic [R_W-1:0]               rem_r;
  logic [Q_W-1:0]               q_r;
  logic [2*SB-1:0]              rad_r;
  logic [SB-1:0]                root_r;
  logic [STEP_W-1:0]            step_r;
  logic                         out_valid_r;
  logic [rlm_pkg::LEVEL_W-1:0]  out_level_r;
  logic                         out_ovf_r;

  logic [SB-1:0]                raw;
  logic [SB-1:0]                mag;
  logic [2*SB-1:0]              sq;
  logic [U_W-1:0]               sub_a;
  logic [U_W-1:0]               sub_b;
  logic [U_W-1:0]               sub_diff;
  logic                         sub_ge;
  logic                         in_fire;
  logic                         room;

  // Magnitude of the incoming sample; the most negative value maps to 2^(SB-1)
  assign raw     = in_ch.sample[SB-1:0];
  assign mag     = raw[SB-1] ? (~raw + SB'(1)) : raw;
  assign sq      = mag_r * mag_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign room    = !out_valid_r || out_ch.ready;

  // Route operands to the shared subtractor
  always_comb begin
    case (state_r)
      ST_DIV: begin
        sub_a = U_W'({rem_r[CNT_W-1:0], q_r[Q_W-1]});
        sub_b = U_W'(cnt_r);
      end
      ST_SQRT: begin
        sub_a = U_W'({rem_r[SB-1:0], rad_r[2*SB-1 -: 2]});
        sub_b = U_W'({root_r, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  rlm_sub_unit #(
    .W (U_W)
  ) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one is loaded now
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            last_r <= in_ch.last;
            mag_r  <= mag;
            if (cnt_r < CNT_W'(MAX_LEN)) begin
              state_r <= ST_ACC;
            end else begin
              ovf_r <= 1'b1;
              if (in_ch.last) begin
                state_r <= ST_LOAD;
              end
            end
          end
        end
        ST_ACC: begin
          sum_r   <= sum_r + SUM_W'(sq);
          cnt_r   <= cnt_r + CNT_W'(1);
          state_r <= last_r ? ST_LOAD : ST_IDLE;
        end
        ST_LOAD: begin
          // Top bits of the sum stay below the count, so they seed the remainder
          rem_r   <= R_W'(sum_r[SUM_W-1 -: CNT_W]);
          q_r     <= sum_r[Q_W-1:0];
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          q_r   <= {q_r[Q_W-2:0], sub_ge};
          if (step_r == STEP_W'(Q_W - 1)) begin
            rad_r   <= {1'b0, q_r[Q_W-2:0], sub_ge};
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= ST_SQRT;
          end else begin
            rem_r  <= R_W'(sub_ge ? sub_diff[CNT_W-1:0] : sub_a[CNT_W-1:0]);
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_SQRT: begin
          rem_r  <= R_W'(sub_ge ? sub_diff[SB:0] : sub_a[SB:0]);
          root_r <= {root_r[SB-2:0], sub_ge};
          rad_r  <= {rad_r[2*SB-3:0], 2'b00};
          if (step_r == STEP_W'(SB - 1)) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_DONE: begin
          // Hand off the level and start a fresh run
          if (room) begin
            out_valid_r <= 1'b1;
            out_level_r <= rlm_pkg::LEVEL_W'(root_r);
            out_ovf_r   <= ovf_r;
            sum_r       <= '0;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.level    = out_level_r;
  assign out_ch.overflow = out_ovf_r;

  // Count never runs past the run limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN))
    else $error("sample count above limit");

  // Divide never starts with an empty count
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != '0))
    else $error("divide by zero count");

  // Partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (CNT_W'(rem_r) < cnt_r))
    else $error("divide remainder out of range");

  // A new result only comes out of the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

endmodule

/* design/rlm_sub_unit.sv */
// Shared subtract and compare: diff = a - b, ge = (a >= b)
module rlm_sub_unit #(
  parameter int W = 18
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  // Extend by one bit so the top bit is the borrow
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

/* test/tb_rms_level_meter.sv */
`timescale 1ns / 100ps

module tb_rms_level_meter;

  localparam int SAMPLE_W     = rlm_pkg::SAMPLE_W;
  localparam int LEVEL_W      = rlm_pkg::LEVEL_W;
  localparam int MAX_LEN      = 65536;
  localparam int SAMPLE_BITS  = 16;
  localparam int RANDOM_WORDS = 1200;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               overflow;
  } level_word_t;

  logic clk;
  logic rst_n;

  rlm_in_if  in_ch();
  rlm_out_if out_ch();

  rms_level_meter #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Running copy of the accumulator state
  bit [46:0] acc_sum;
  bit [16:0] acc_count;
  bit        acc_ovf;

  level_word_t pending_levels[$];
  int          mismatches;
  bit          in_steady;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Drive every input to a known value from time zero
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // floor(sqrt(v)), built one root bit at a time from the top
  function automatic bit [LEVEL_W-1:0] floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[LEVEL_W-1:0];
  endfunction

  // Fold one accepted sample into the running sums; close the run on last
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int              v;
    longint unsigned mag;
    longint unsigned mean;
    level_word_t     w;
    v = $signed(smp[SAMPLE_BITS-1:0]);
    mag = (v < 0) ? -v : v;
    if (acc_count < MAX_LEN) begin
      acc_sum   = acc_sum + 47'(mag * mag);
      acc_count = acc_count + 17'd1;
    end else begin
      acc_ovf = 1'b1;
    end
    if (lst) begin
      mean = longint'(acc_sum) / longint'(acc_count);
      w.level    = floor_root(mean);
      w.overflow = acc_ovf;
      pending_levels.push_back(w);
      acc_sum   = '0;
      acc_count = '0;
      acc_ovf   = 1'b0;
    end
  endtask

  // Offer one sample word and hold it until the block takes it
  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    in_ch.last   <= lst;
    do @(posedge clk); while (!in_ch.ready);
    absorb_sample(smp, lst);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    if (r == 2) return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
    return SAMPLE_W'($urandom);
  endfunction

  // Receiver: random stalls, with occasional stretches of steady ready
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(20, 100);
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end else begin
        n = pick_gap();
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted result word with the oldest expected level
  always @(posedge clk) begin
    level_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: level=%0d overflow=%0b",
                   out_ch.level, out_ch.overflow);
      end else begin
        exp_w = pending_levels.pop_front();
        if (out_ch.level !== exp_w.level || out_ch.overflow !== exp_w.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word: expected level=%0d overflow=%0b, got level=%0d overflow=%0b",
                     exp_w.level, exp_w.overflow, out_ch.level, out_ch.overflow);
        end
      end
    end
  end

  // One-sample runs: zero, plus and minus one, the extremes of the sample range and a mid value
  task automatic test_single_samples();
    send_word(16'sh0000, 1'b1);
    send_word(16'sh0001, 1'b1);
    send_word(16'shffff, 1'b1);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh3039, 1'b1);
  endtask

  // Short runs: most negative only, mixed extremes, a rounded-down mean, mixed signs
  task automatic test_short_runs();
    repeat (3) send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b1);
    send_word(16'sh0003, 1'b0);
    send_word(16'sh0004, 1'b1);
    send_word(16'shfffe, 1'b0);
    send_word(16'sh0001, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b1);
  endtask

  // Random runs, mostly short, a few long, some sent without gaps
  task automatic test_random_runs();
    int sent;
    int len;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
      in_steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++)
        send_word(rand_sample(), i == len - 1);
      sent += len;
    end
    in_steady = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    in_steady  = 1'b0;
    acc_sum    = '0;
    acc_count  = '0;
    acc_ovf    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_samples();
    test_short_runs();
    test_random_runs();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("rms_level_meter: match");
    else
      $display("rms_level_meter: mismatch");
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #30_000_000;
    $display("rms_level_meter: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
design/rlm_pkg.sv
design/rlm_if.sv
design/rlm_sub_unit.sv
design/rms_level_meter.sv
test/tb_rms_level_meter.sv
